// ===== design/mwm_pkg.sv =====
package mwm_pkg;

    // widths of the command, the exact sums and the speed path
    localparam int NUM_WHEELS = 4;
    localparam int VEL_W      = 16;
    localparam int SUM_W      = 18;
    localparam int MAG_W      = 17;
    localparam int SPD_W      = 8;
    localparam int NUM_W      = MAG_W + SPD_W;
    localparam int QUO_W      = 8;
    localparam int DIR_W      = 2;
    localparam int LIMIT_W    = 16;

    // clip applied to every wheel magnitude before it becomes a duty
    localparam logic [LIMIT_W-1:0] DUTY_LIMIT = 16'd255;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_COAST = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV   = 2'd2;

    // wheel lanes
    localparam int WHL_FL = 0;
    localparam int WHL_FR = 1;
    localparam int WHL_RL = 2;
    localparam int WHL_RR = 3;

    // motion command
    typedef struct packed {
        logic signed [VEL_W-1:0] vel_forward;
        logic signed [VEL_W-1:0] vel_sideways;
        logic signed [VEL_W-1:0] vel_rotate;
    } t_cmd;

    // wheel drive result
    typedef struct packed {
        logic [SPD_W-1:0] duty_front_left;
        logic [DIR_W-1:0] dir_front_left;
        logic [SPD_W-1:0] duty_front_right;
        logic [DIR_W-1:0] dir_front_right;
        logic [SPD_W-1:0] duty_rear_left;
        logic [DIR_W-1:0] dir_rear_left;
        logic [SPD_W-1:0] duty_rear_right;
        logic [DIR_W-1:0] dir_rear_right;
    } t_wheel_out;

    // item carried through the scaling divider
    typedef struct packed {
        logic [NUM_WHEELS-1:0]            neg;
        logic [NUM_WHEELS-1:0][SPD_W-1:0] direct;
        logic                             scale;
        logic [MAG_W-1:0]                 divisor;
        logic [NUM_WHEELS-1:0][MAG_W-1:0] rem;
        logic [NUM_WHEELS-1:0][QUO_W-1:0] num_lo;
        logic [NUM_WHEELS-1:0][QUO_W-1:0] quo;
    } t_div_item;

endpackage

// ===== design/mwm_stream_if.sv =====
interface mwm_stream_if #(parameter type T = logic) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ===== design/mwm_divider.sv =====
module mwm_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mwm_pkg::t_div_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output mwm_pkg::t_div_item  o_item
);
    import mwm_pkg::*;

    localparam int NUM_STEPS = QUO_W;

    // one restoring step: one quotient bit for every wheel lane
    function automatic t_div_item div_step(input t_div_item a);
        t_div_item        b;
        logic [MAG_W:0]   trial;
        logic [MAG_W:0]   diff;
        b = a;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            trial = {a.rem[k], a.num_lo[k][QUO_W-1]};
            diff  = trial - {1'b0, a.divisor};
            b.num_lo[k] = {a.num_lo[k][QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, a.divisor}) begin
                b.rem[k] = diff[MAG_W-1:0];
                b.quo[k] = {a.quo[k][QUO_W-2:0], 1'b1};
            end else begin
                b.rem[k] = trial[MAG_W-1:0];
                b.quo[k] = {a.quo[k][QUO_W-2:0], 1'b0};
            end
        end
        return b;
    endfunction

    logic [NUM_STEPS-1:0] r_valid;
    t_div_item            r_item [NUM_STEPS];
    t_div_item            n_item [NUM_STEPS];
    logic [NUM_STEPS:0]   stage_ready;

    // a stage takes a new item when it is empty or its item moves on
    always_comb begin
        stage_ready[NUM_STEPS] = i_ready;
        for (int k = NUM_STEPS - 1; k >= 0; k--) begin
            stage_ready[k] = !r_valid[k] || stage_ready[k+1];
        end
    end

    // divider stages
    for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
        if (g == 0) begin : g_first
            assign n_item[g] = div_step(i_item);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[g] <= 1'b0;
                end else if (stage_ready[g]) begin
                    r_valid[g] <= i_valid;
                end
            end
        end else begin : g_next
            assign n_item[g] = div_step(r_item[g-1]);
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[g] <= 1'b0;
                end else if (stage_ready[g]) begin
                    r_valid[g] <= r_valid[g-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (stage_ready[g]) begin
                r_item[g] <= n_item[g];
            end
        end
    end

    assign o_ready = stage_ready[0];
    assign o_valid = r_valid[NUM_STEPS-1];
    assign o_item  = r_item[NUM_STEPS-1];

endmodule

// ===== design/mecanum_wheel_mixer.sv =====
// mecanum wheel mixer
// i_cmd (sink) carries one motion command per transfer: forward, sideways
// and rotation velocities, each signed 16 bits. o_wheel (source) carries one
// result per command: duty and direction code for the four wheels.
// i_max_speed_we writes i_max_speed, the largest wheel magnitude that passes
// unscaled; write it only while no command is in flight.
// Stages: a result passes the sum stage, max/multiply stage, eight divider
// stages and drive stage, each registered, on its way to o_wheel.
// Throughput: one command per cycle unless o_wheel stalls; every stage is a
// register; the scaling uses an eight-stage divider, one quotient bit a stage.
// Reset clears every stage valid and sets max_speed to 255.
// When the receiver stalls, the result holds on o_wheel; upstream stages
// keep taking commands until every stage is full, then i_cmd.ready drops.
module mecanum_wheel_mixer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_max_speed_we,
    input  logic [mwm_pkg::SPD_W-1:0] i_max_speed,
    mwm_stream_if.sink                i_cmd,
    mwm_stream_if.source              o_wheel
);
    import mwm_pkg::*;

    // max speed register
    logic [SPD_W-1:0] r_max_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= 8'd255;
        end else if (i_max_speed_we) begin
            r_max_speed <= i_max_speed;
        end
    end

    // stage handshake chain
    logic s1_ready;
    logic s2_ready;
    logic div_ready;
    logic div_valid;
    logic out_ready;

    logic                             r_s1_valid;
    logic [NUM_WHEELS-1:0]            r_s1_neg;
    logic [NUM_WHEELS-1:0][MAG_W-1:0] r_s1_mag;
    logic [NUM_WHEELS-1:0]            n_s1_neg;
    logic [NUM_WHEELS-1:0][MAG_W-1:0] n_s1_mag;

    logic      r_s2_valid;
    t_div_item r_s2_item;
    t_div_item n_s2_item;
    t_div_item div_item;

    logic       r_out_valid;
    t_wheel_out r_out;
    t_wheel_out n_out;

    assign out_ready   = !r_out_valid || o_wheel.ready;
    assign s2_ready    = !r_s2_valid || div_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign i_cmd.ready = s1_ready;

    // exact wheel sums and magnitudes
    always_comb begin
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] w;
        logic signed [SUM_W-1:0] sum [NUM_WHEELS];
        x = SUM_W'(i_cmd.data.vel_forward);
        y = SUM_W'(i_cmd.data.vel_sideways);
        w = SUM_W'(i_cmd.data.vel_rotate);
        sum[WHL_FL] = x + y + w;
        sum[WHL_FR] = x - y - w;
        sum[WHL_RL] = x - y + w;
        sum[WHL_RR] = x + y - w;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            n_s1_neg[k] = sum[k][SUM_W-1];
            n_s1_mag[k] = sum[k][SUM_W-1] ? MAG_W'(-sum[k]) : MAG_W'(sum[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_neg <= n_s1_neg;
            r_s1_mag <= n_s1_mag;
        end
    end

    // largest magnitude, scale decision and numerators
    always_comb begin
        logic [MAG_W-1:0] max_a;
        logic [MAG_W-1:0] max_b;
        logic [MAG_W-1:0] largest;
        logic [NUM_W-1:0] num;
        max_a   = (r_s1_mag[WHL_FL] > r_s1_mag[WHL_FR]) ? r_s1_mag[WHL_FL] : r_s1_mag[WHL_FR];
        max_b   = (r_s1_mag[WHL_RL] > r_s1_mag[WHL_RR]) ? r_s1_mag[WHL_RL] : r_s1_mag[WHL_RR];
        largest = (max_a > max_b) ? max_a : max_b;
        n_s2_item.neg     = r_s1_neg;
        n_s2_item.scale   = largest > MAG_W'(r_max_speed);
        n_s2_item.divisor = largest;
        for (int k = 0; k < NUM_WHEELS; k++) begin
            num = NUM_W'(r_s1_mag[k]) * NUM_W'(r_max_speed);
            n_s2_item.direct[k] = r_s1_mag[k][SPD_W-1:0];
            n_s2_item.rem[k]    = num[NUM_W-1:QUO_W];
            n_s2_item.num_lo[k] = num[QUO_W-1:0];
            n_s2_item.quo[k]    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready) begin
            r_s2_item <= n_s2_item;
        end
    end

    // proportional scaling: magnitude * max_speed / largest
    mwm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .o_ready (div_ready),
        .i_item  (r_s2_item),
        .o_valid (div_valid),
        .i_ready (out_ready),
        .o_item  (div_item)
    );

    // clip, duty and direction per wheel
    always_comb begin
        logic [SPD_W-1:0] spd;
        logic [SPD_W-1:0] duty [NUM_WHEELS];
        logic [DIR_W-1:0] dir [NUM_WHEELS];
        for (int k = 0; k < NUM_WHEELS; k++) begin
            spd = div_item.scale ? div_item.quo[k] : div_item.direct[k];
            if (LIMIT_W'(spd) > DUTY_LIMIT) begin
                duty[k] = DUTY_LIMIT[SPD_W-1:0];
            end else begin
                duty[k] = spd;
            end
            if (spd == '0) begin
                dir[k] = DIR_COAST;
            end else if (div_item.neg[k]) begin
                dir[k] = DIR_REV;
            end else begin
                dir[k] = DIR_FWD;
            end
        end
        n_out.duty_front_left  = duty[WHL_FL];
        n_out.dir_front_left   = dir[WHL_FL];
        n_out.duty_front_right = duty[WHL_FR];
        n_out.dir_front_right  = dir[WHL_FR];
        n_out.duty_rear_left   = duty[WHL_RL];
        n_out.dir_rear_left    = dir[WHL_RL];
        n_out.duty_rear_right  = duty[WHL_RR];
        n_out.dir_rear_right   = dir[WHL_RR];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out <= n_out;
        end
    end

    assign o_wheel.valid = r_out_valid;
    assign o_wheel.data  = r_out;

endmodule

// ===== design/mwm_checker.sv =====
module mwm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input mwm_pkg::t_wheel_out i_data
);
    import mwm_pkg::*;

    // no result is shown right after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> i_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> $stable(i_data))
        else $error("result changed while stalled");

    // a coasting wheel has no duty and a driven wheel has some
    a_duty_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |->
            ((i_data.duty_front_left == '0) == (i_data.dir_front_left == DIR_COAST)) &&
            ((i_data.duty_front_right == '0) == (i_data.dir_front_right == DIR_COAST)) &&
            ((i_data.duty_rear_left == '0) == (i_data.dir_rear_left == DIR_COAST)) &&
            ((i_data.duty_rear_right == '0) == (i_data.dir_rear_right == DIR_COAST)))
        else $error("duty and direction disagree");

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_wheel.valid),
    .i_ready (o_wheel.ready),
    .i_data  (o_wheel.data)
);
